### rtl/i2cscr_pkg.sv
package i2cscr_pkg;

    // Action codes carried by one request.
    localparam logic [2:0] ACT_BUS_START    = 3'd0;
    localparam logic [2:0] ACT_BUS_STOP     = 3'd1;
    localparam logic [2:0] ACT_BUS_WRITE    = 3'd2;
    localparam logic [2:0] ACT_BUS_READ     = 3'd3;
    localparam logic [2:0] ACT_DIRECT_WRITE = 3'd4;
    localparam logic [2:0] ACT_DIRECT_READ  = 3'd5;

    // Fixed identification bytes.
    localparam logic [7:0] ID_VENDOR_LOW   = 8'hCC;
    localparam logic [7:0] ID_VENDOR_HIGH  = 8'h04;
    localparam logic [7:0] ID_PRODUCT_LOW  = 8'h01;
    localparam logic [7:0] ID_PRODUCT_HIGH = 8'h13;

    // Register addresses.
    localparam logic [7:0] ADDR_ID_VENDOR_LOW   = 8'h00;
    localparam logic [7:0] ADDR_ID_VENDOR_HIGH  = 8'h01;
    localparam logic [7:0] ADDR_ID_PRODUCT_LOW  = 8'h02;
    localparam logic [7:0] ADDR_ID_PRODUCT_HIGH = 8'h03;
    localparam logic [7:0] ADDR_MODE_CTRL_ONE   = 8'h04;
    localparam logic [7:0] ADDR_OTG_CTRL        = 8'h06;
    localparam logic [7:0] ADDR_INT_LATCH       = 8'h0A;
    localparam logic [7:0] ADDR_INT_ENABLE_LOW  = 8'h0C;
    localparam logic [7:0] ADDR_INT_ENABLE_HIGH = 8'h0E;
    localparam logic [7:0] ADDR_MODE_CTRL_TWO   = 8'h12;

    // Reset values of the set/clear registers.
    localparam logic [7:0] OTG_CTRL_RESET      = 8'h0C;
    localparam logic [7:0] MODE_CTRL_TWO_RESET = 8'h04;

    // One request as held in the input register.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [7:0] reg_address;
    } request_t;

endpackage

### rtl/i2cscr_core.sv
module i2cscr_core
    import i2cscr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       exec,
    input  request_t   req,
    output logic [7:0] read_data,
    output logic       irq_active
);

    logic       data_phase_reg;
    logic       data_phase_next;
    logic [7:0] reg_pointer_reg;
    logic [7:0] reg_pointer_next;
    logic [7:0] mode_ctrl_one_reg;
    logic [7:0] mode_ctrl_one_next;
    logic [7:0] otg_ctrl_reg;
    logic [7:0] otg_ctrl_next;
    logic [7:0] int_latch_reg;
    logic [7:0] int_latch_next;
    logic [7:0] int_enable_low_reg;
    logic [7:0] int_enable_low_next;
    logic [7:0] int_enable_high_reg;
    logic [7:0] int_enable_high_next;
    logic [7:0] mode_ctrl_two_reg;
    logic [7:0] mode_ctrl_two_next;

    logic [7:0] eff_addr;
    logic       do_write;
    logic       do_read;

    // Applies a set or clear write when the address hits the register's pair.
    function automatic logic [7:0] apply_write(
        input logic [7:0] cur,
        input logic [7:0] base,
        input logic [7:0] addr,
        input logic [7:0] value,
        input logic       wr
    );
        logic [7:0] res;
        res = cur;
        if (wr && (addr[7:1] == base[7:1]))
        begin
            if (addr[0])
            begin
                res = cur & ~value;
            end
            else
            begin
                res = cur | value;
            end
        end
        return res;
    endfunction

    // Bus accesses go through the pointer, direct accesses use their own address.
    always_comb
    begin
        eff_addr = req.reg_address;
        do_write = 1'b0;
        do_read  = 1'b0;
        case (req.action)
            ACT_BUS_WRITE:
            begin
                eff_addr = reg_pointer_reg;
                do_write = data_phase_reg;
            end
            ACT_BUS_READ:
            begin
                eff_addr = reg_pointer_reg;
                do_read  = 1'b1;
            end
            ACT_DIRECT_WRITE:
            begin
                do_write = 1'b1;
            end
            ACT_DIRECT_READ:
            begin
                do_read = 1'b1;
            end
            default:
            begin
                do_write = 1'b0;
            end
        endcase
    end

    // Read decode; clear addresses, the source register and holes read zero.
    always_comb
    begin
        read_data = 8'h00;
        if (do_read)
        begin
            case (eff_addr)
                ADDR_ID_VENDOR_LOW:   read_data = ID_VENDOR_LOW;
                ADDR_ID_VENDOR_HIGH:  read_data = ID_VENDOR_HIGH;
                ADDR_ID_PRODUCT_LOW:  read_data = ID_PRODUCT_LOW;
                ADDR_ID_PRODUCT_HIGH: read_data = ID_PRODUCT_HIGH;
                ADDR_MODE_CTRL_ONE:   read_data = mode_ctrl_one_reg;
                ADDR_OTG_CTRL:        read_data = otg_ctrl_reg;
                ADDR_INT_LATCH:       read_data = int_latch_reg;
                ADDR_INT_ENABLE_LOW:  read_data = int_enable_low_reg;
                ADDR_INT_ENABLE_HIGH: read_data = int_enable_high_reg;
                ADDR_MODE_CTRL_TWO:   read_data = mode_ctrl_two_reg;
                default:              read_data = 8'h00;
            endcase
        end
    end

    // Set/clear register updates.
    always_comb
    begin
        mode_ctrl_one_next = apply_write(mode_ctrl_one_reg, ADDR_MODE_CTRL_ONE,
                                         eff_addr, req.data_byte, do_write);
        otg_ctrl_next = apply_write(otg_ctrl_reg, ADDR_OTG_CTRL,
                                    eff_addr, req.data_byte, do_write);
        int_latch_next = apply_write(int_latch_reg, ADDR_INT_LATCH,
                                     eff_addr, req.data_byte, do_write);
        int_enable_low_next = apply_write(int_enable_low_reg, ADDR_INT_ENABLE_LOW,
                                          eff_addr, req.data_byte, do_write);
        int_enable_high_next = apply_write(int_enable_high_reg, ADDR_INT_ENABLE_HIGH,
                                           eff_addr, req.data_byte, do_write);
        mode_ctrl_two_next = apply_write(mode_ctrl_two_reg, ADDR_MODE_CTRL_TWO,
                                         eff_addr, req.data_byte, do_write);
    end

    // Phase and pointer sequencing.
    always_comb
    begin
        data_phase_next  = data_phase_reg;
        reg_pointer_next = reg_pointer_reg;
        case (req.action)
            ACT_BUS_START, ACT_BUS_STOP:
            begin
                data_phase_next = 1'b0;
            end
            ACT_BUS_WRITE:
            begin
                data_phase_next = 1'b1;
                if (data_phase_reg)
                begin
                    reg_pointer_next = reg_pointer_reg + 8'd1;
                end
                else
                begin
                    reg_pointer_next = req.data_byte;
                end
            end
            ACT_BUS_READ:
            begin
                reg_pointer_next = reg_pointer_reg + 8'd1;
            end
            default:
            begin
                data_phase_next = data_phase_reg;
            end
        endcase
    end

    // The interrupt output reflects the latch after this request's update.
    assign irq_active = (int_latch_next != 8'h00);

    // State registers, updated once per executed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_phase_reg      <= 1'b0;
            reg_pointer_reg     <= 8'h00;
            mode_ctrl_one_reg   <= 8'h00;
            otg_ctrl_reg        <= OTG_CTRL_RESET;
            int_latch_reg       <= 8'h00;
            int_enable_low_reg  <= 8'h00;
            int_enable_high_reg <= 8'h00;
            mode_ctrl_two_reg   <= MODE_CTRL_TWO_RESET;
        end
        else if (exec)
        begin
            data_phase_reg      <= data_phase_next;
            reg_pointer_reg     <= reg_pointer_next;
            mode_ctrl_one_reg   <= mode_ctrl_one_next;
            otg_ctrl_reg        <= otg_ctrl_next;
            int_latch_reg       <= int_latch_next;
            int_enable_low_reg  <= int_enable_low_next;
            int_enable_high_reg <= int_enable_high_next;
            mode_ctrl_two_reg   <= mode_ctrl_two_next;
        end
    end

endmodule

### rtl/i2c_set_clear_register_file.sv
// Byte-level I2C slave register file with set/clear register pairs. Each
// request (bus start, stop, write byte, read byte, or a direct write/read at
// an explicit address) gives exactly one result with the read byte and the
// interrupt state. A request is captured in an input register and executed
// against the register file once the result register is free or being drained;
// the outcome lands in a result register, and one request per cycle is sustained
// while results are taken as soon as they are offered.
// While a result waits to be taken, the input register can still take one
// request; after that the input stalls until the result is taken.
module i2c_set_clear_register_file
    import i2cscr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    input  logic [7:0] reg_address,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] read_data,
    output logic       irq_active
);

    logic       in_valid_reg;
    request_t   req_reg;
    logic       out_valid_reg;
    logic [7:0] read_data_reg;
    logic       irq_reg;
    logic       advance;
    logic [7:0] core_read_data;
    logic       core_irq;

    // A request moves on when the result register is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            req_reg.action      <= action;
            req_reg.data_byte   <= data_byte;
            req_reg.reg_address <= reg_address;
        end
    end

    // Register file and access decode.
    i2cscr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .exec       (advance),
        .req        (req_reg),
        .read_data  (core_read_data),
        .irq_active (core_irq)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= core_read_data;
            irq_reg       <= core_irq;
        end
    end

    assign res_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign irq_active = irq_reg;

endmodule

### verif/i2c_set_clear_register_file_tb.sv
module i2c_set_clear_register_file_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cscr_pkg::*;

    // Codes the block treats as no operation, and the read-only interrupt source.
    localparam logic [2:0] ACT_RESERVED_A  = 3'd6;
    localparam logic [2:0] ACT_RESERVED_B  = 3'd7;
    localparam logic [7:0] ADDR_INT_SOURCE = 8'h08;
    localparam logic [7:0] ADDR_UNDEFINED  = 8'hFF;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int MAX_WAIT        = 13;
    localparam int WATCHDOG_LIMIT  = 300;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_active;
    } reg_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    logic [2:0] action = ACT_BUS_START;
    logic [7:0] data_byte = 8'h00;
    logic [7:0] reg_address = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [7:0] read_data;
    logic       irq_active;

    request_t    pending_requests[$];
    reg_result_t expected_results[$];
    int          error_count = 0;

    // Shadow copy of the register file.
    logic       shadow_data_phase;
    logic [7:0] shadow_pointer;
    logic [7:0] shadow_mode_ctrl_one;
    logic [7:0] shadow_otg_ctrl;
    logic [7:0] shadow_int_latch;
    logic [7:0] shadow_int_enable_low;
    logic [7:0] shadow_int_enable_high;
    logic [7:0] shadow_mode_ctrl_two;

    i2c_set_clear_register_file u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .action      (action),
        .data_byte   (data_byte),
        .reg_address (reg_address),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .read_data   (read_data),
        .irq_active  (irq_active)
    );

    always #6 clk = ~clk;

    // A set address ORs the value in, a clear address ANDs it out.
    function automatic logic [7:0] set_or_clear(input logic [7:0] old_value,
                                                input logic [7:0] value,
                                                input logic       clear);
        return clear ? (old_value & ~value) : (old_value | value);
    endfunction

    function automatic void write_shadow(input logic [7:0] addr, input logic [7:0] value);
        logic [7:0] pair_base;
        pair_base = {addr[7:1], 1'b0};
        case (pair_base)
            ADDR_MODE_CTRL_ONE:
                shadow_mode_ctrl_one = set_or_clear(shadow_mode_ctrl_one, value, addr[0]);
            ADDR_OTG_CTRL:
                shadow_otg_ctrl = set_or_clear(shadow_otg_ctrl, value, addr[0]);
            ADDR_INT_LATCH:
                shadow_int_latch = set_or_clear(shadow_int_latch, value, addr[0]);
            ADDR_INT_ENABLE_LOW:
                shadow_int_enable_low = set_or_clear(shadow_int_enable_low, value, addr[0]);
            ADDR_INT_ENABLE_HIGH:
                shadow_int_enable_high = set_or_clear(shadow_int_enable_high, value, addr[0]);
            ADDR_MODE_CTRL_TWO:
                shadow_mode_ctrl_two = set_or_clear(shadow_mode_ctrl_two, value, addr[0]);
            default: ;
        endcase
    endfunction

    // ID bytes are fixed; clear addresses, the interrupt source and holes read zero.
    function automatic logic [7:0] read_shadow(input logic [7:0] addr);
        case (addr)
            ADDR_ID_VENDOR_LOW:   return ID_VENDOR_LOW;
            ADDR_ID_VENDOR_HIGH:  return ID_VENDOR_HIGH;
            ADDR_ID_PRODUCT_LOW:  return ID_PRODUCT_LOW;
            ADDR_ID_PRODUCT_HIGH: return ID_PRODUCT_HIGH;
            ADDR_MODE_CTRL_ONE:   return shadow_mode_ctrl_one;
            ADDR_OTG_CTRL:        return shadow_otg_ctrl;
            ADDR_INT_LATCH:       return shadow_int_latch;
            ADDR_INT_ENABLE_LOW:  return shadow_int_enable_low;
            ADDR_INT_ENABLE_HIGH: return shadow_int_enable_high;
            ADDR_MODE_CTRL_TWO:   return shadow_mode_ctrl_two;
            default:              return 8'h00;
        endcase
    endfunction

    // Applies one accepted request to the shadow and queues the result it gives.
    function automatic void predict_register_access(input request_t req);
        reg_result_t res;
        res.read_data = 8'h00;
        case (req.action)
            ACT_BUS_START, ACT_BUS_STOP:
                shadow_data_phase = 1'b0;
            ACT_BUS_WRITE:
                if (!shadow_data_phase)
                begin
                    shadow_pointer    = req.data_byte;
                    shadow_data_phase = 1'b1;
                end
                else
                begin
                    write_shadow(shadow_pointer, req.data_byte);
                    shadow_pointer = shadow_pointer + 8'd1;
                end
            ACT_BUS_READ:
            begin
                res.read_data  = read_shadow(shadow_pointer);
                shadow_pointer = shadow_pointer + 8'd1;
            end
            ACT_DIRECT_WRITE:
                write_shadow(req.reg_address, req.data_byte);
            ACT_DIRECT_READ:
                res.read_data = read_shadow(req.reg_address);
            default: ;
        endcase
        res.irq_active = (shadow_int_latch != 8'h00);
        expected_results.push_back(res);
    endfunction

    function automatic void queue_request(input logic [2:0] act, input logic [7:0] value,
                                          input logic [7:0] addr);
        request_t req;
        req.action      = act;
        req.data_byte   = value;
        req.reg_address = addr;
        pending_requests.push_back(req);
    endfunction

    // Mostly the populated low part of the map, now and then anywhere.
    function automatic logic [7:0] pick_address();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, 8'h14));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int draw_wait(input logic busy_mode);
        return busy_mode ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // Request driver: presents queued requests with random gaps between them.
    logic driver_busy_mode = 1'b1;
    int   driver_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shadow_data_phase      = 1'b0;
            shadow_pointer         = 8'h00;
            shadow_mode_ctrl_one   = 8'h00;
            shadow_otg_ctrl        = OTG_CTRL_RESET;
            shadow_int_latch       = 8'h00;
            shadow_int_enable_low  = 8'h00;
            shadow_int_enable_high = 8'h00;
            shadow_mode_ctrl_two   = MODE_CTRL_TWO_RESET;
        end
        else if (cmd_valid && cmd_ready)
        begin
            request_t accepted;
            request_t next_req;
            int       gap;
            accepted.action      = action;
            accepted.data_byte   = data_byte;
            accepted.reg_address = reg_address;
            predict_register_access(accepted);
            if ($urandom_range(0, 59) == 0)
                driver_busy_mode = ~driver_busy_mode;
            gap = draw_wait(driver_busy_mode);
            if (gap == 0 && pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                action      <= next_req.action;
                data_byte   <= next_req.data_byte;
                reg_address <= next_req.reg_address;
            end
            else
            begin
                cmd_valid  <= 1'b0;
                driver_gap <= gap;
            end
        end
        else if (!cmd_valid)
        begin
            request_t next_req;
            if (driver_gap > 1)
                driver_gap <= driver_gap - 1;
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                action      <= next_req.action;
                data_byte   <= next_req.data_byte;
                reg_address <= next_req.reg_address;
                cmd_valid   <= 1'b1;
                driver_gap  <= 0;
            end
        end
    end

    // Result monitor: takes results with random stalls and checks each one.
    logic monitor_busy_mode = 1'b0;
    int   monitor_stall = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (res_valid && res_ready)
        begin
            reg_result_t want;
            int          stall;
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: read_data=%0h irq_active=%0b",
                       read_data, irq_active);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %0h, actual %0h", want.read_data, read_data);
                    error_count++;
                end
                if (irq_active !== want.irq_active)
                begin
                    $error("irq_active: expected %0b, actual %0b", want.irq_active, irq_active);
                    error_count++;
                end
            end
            if ($urandom_range(0, 59) == 0)
                monitor_busy_mode = ~monitor_busy_mode;
            stall = draw_wait(monitor_busy_mode);
            if (stall != 0)
            begin
                res_ready     <= 1'b0;
                monitor_stall <= stall;
            end
        end
        else if (!res_ready)
        begin
            if (monitor_stall <= 1)
                res_ready <= 1'b1;
            monitor_stall <= monitor_stall - 1;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("i2c_set_clear_register_file: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int queued;
        int burst;

        // Reset values, ID bytes, clear addresses and holes in the map.
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_ID_VENDOR_LOW);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_ID_VENDOR_HIGH);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_ID_PRODUCT_LOW);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_ID_PRODUCT_HIGH);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_OTG_CTRL);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_MODE_CTRL_TWO);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_OTG_CTRL | 8'h01);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_INT_SOURCE);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_UNDEFINED);

        // Latch set raises the interrupt; writes to fixed and undefined places are dropped.
        queue_request(ACT_DIRECT_WRITE, 8'hFF, ADDR_INT_LATCH);
        queue_request(ACT_DIRECT_WRITE, 8'h55, ADDR_ID_VENDOR_LOW);
        queue_request(ACT_DIRECT_WRITE, 8'hFF, ADDR_INT_SOURCE);
        queue_request(ACT_DIRECT_WRITE, 8'hFF, ADDR_UNDEFINED);
        queue_request(ACT_DIRECT_READ, 8'h00, ADDR_INT_LATCH);
        queue_request(ACT_DIRECT_WRITE, 8'hFF, ADDR_INT_LATCH | 8'h01);

        // Bus read while still in address phase, then pointer wrap at the top.
        queue_request(ACT_BUS_READ, 8'hFF, 8'h00);
        queue_request(ACT_BUS_START, 8'h00, 8'hFF);
        queue_request(ACT_BUS_WRITE, 8'hFE, 8'h00);
        queue_request(ACT_BUS_WRITE, 8'hA5, 8'h00);
        queue_request(ACT_BUS_WRITE, 8'h3C, 8'h00);
        queue_request(ACT_BUS_READ, 8'h00, 8'h00);

        // Repeated start, a set write and a clear-address read on the bus, unused codes, stop.
        queue_request(ACT_BUS_START, 8'h00, 8'h00);
        queue_request(ACT_BUS_WRITE, ADDR_MODE_CTRL_ONE, 8'h00);
        queue_request(ACT_BUS_WRITE, 8'hFF, 8'h00);
        queue_request(ACT_BUS_READ, 8'h00, 8'h00);
        queue_request(ACT_RESERVED_A, 8'hFF, 8'hFF);
        queue_request(ACT_RESERVED_B, 8'hFF, 8'hFF);
        queue_request(ACT_BUS_STOP, 8'h00, 8'h00);
        queue_request(ACT_BUS_WRITE, 8'h00, 8'h00);

        // Random part: mostly framed bus transfers, the rest direct accesses and noise.
        queued = 0;
        while (queued < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                queue_request($urandom_range(0, 3) == 0 ? ACT_BUS_STOP : ACT_BUS_START,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                queue_request(ACT_BUS_WRITE, pick_address(), 8'($urandom_range(0, 255)));
                burst = $urandom_range(1, 6);
                queued += 2 + burst;
                repeat (burst)
                    queue_request($urandom_range(0, 1) ? ACT_BUS_WRITE : ACT_BUS_READ,
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                begin
                    queue_request(ACT_BUS_STOP, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
                    queued++;
                end
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1: queue_request(ACT_DIRECT_WRITE, 8'($urandom_range(0, 255)),
                                        pick_address());
                    2, 3: queue_request(ACT_DIRECT_READ, 8'($urandom_range(0, 255)),
                                        pick_address());
                    default: queue_request(3'($urandom_range(0, 7)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
                endcase
                queued++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Checked away from the active edge so the driver's updates have settled.
        while (pending_requests.size() != 0 || cmd_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("i2c_set_clear_register_file: match");
        else
            $display("i2c_set_clear_register_file: mismatch");
        $finish;
    end

endmodule
